>>> hdl/rsch_pkg.sv
package rsch_pkg;

    // Table geometry
    localparam int SLOTS = 8;
    localparam int IDX_W = $clog2(SLOTS);
    typedef logic [IDX_W-1:0] t_idx;

    // Command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_BLOCK   = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK = 3'd4;
    localparam logic [2:0] CMD_ALARM   = 3'd5;
    localparam logic [2:0] CMD_QUERY   = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ON     = 2'd1;
    localparam logic [1:0] KIND_OFF    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_HMIN   = 3'd2;
    localparam logic [2:0] CFG_HMAX   = 3'd3;
    localparam logic [2:0] CFG_OFFSET = 3'd4;

    // Flag bit positions
    localparam int FB_ON     = 0;
    localparam int FB_RELAY2 = 1;
    localparam int FB_DAILY  = 2;
    localparam int FB_WEEKLY = 3;
    localparam int FB_TEMP   = 4;
    localparam int FB_BLOCK  = 5;
    localparam int FB_OFF    = 6;

    // Repeat periods and preheat guard
    localparam logic [33:0] DAY_S         = 34'd86400;
    localparam logic [33:0] WEEK_S        = 34'd604800;
    localparam logic [32:0] PREHEAT_GUARD = 33'd301;

    // Period / 128, and reciprocals scaled by 2^REC_SH
    localparam int          REC_SH = 35;
    localparam logic [28:0] DAY_C  = 29'd675;
    localparam logic [28:0] WEEK_C = 29'd4725;
    localparam logic [25:0] DAY_M  = 26'((64'd1 << REC_SH) / 64'd675);
    localparam logic [25:0] WEEK_M = 26'((64'd1 << REC_SH) / 64'd4725);

    // One table entry
    typedef struct packed {
        logic [31:0] tm;
        logic [6:0]  flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> hdl/rsch_ram.sv
module rsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> hdl/relay_event_scheduler.sv
// Relay event scheduler: a table of timed relay events held in a small RAM.
// Input channel (i_in_valid / o_in_stall) takes one command word with its
// fields; output channel (o_out_valid / i_out_stall) returns result words.
// Every command gives one status word with o_last set; an alarm command first
// gives one relay word per firing slot that is not blocked, in slot order.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// the register chosen by i_cfg_index with i_cfg_data.
// Clear and unknown commands go straight to the status word; block, unblock and
// query first read one slot. Add and remove walk every slot through the RAM,
// and a slot whose repeat is stepped takes two registered multiplies for the
// period remainder. Alarm walks the slots too, after the preheat multiply and
// clamp. One command is worked on at a time; the next is taken once the status
// word sits in the output register.
// A stalled receiver holds the output register; the walk waits on it before
// loading a relay word or the status word.
// Reset empties the table (per-slot valid bits), clears the alarm and loads
// the configuration reset values. No clearing pass is needed.
module relay_event_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_current_time,
    input  logic [31:0] i_event_time,
    input  logic [3:0]  i_slot,
    input  logic        i_turn_on,
    input  logic        i_relay_select,
    input  logic        i_repeat_daily,
    input  logic        i_repeat_weekly,
    input  logic        i_use_temperature,
    input  logic signed [7:0] i_outside_temperature,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_relay_number,
    output logic        o_success,
    output logic [3:0]  o_result_slot,
    output logic [31:0] o_alarm_time,
    output logic        o_alarm_valid,
    output logic [31:0] o_read_time,
    output logic [6:0]  o_read_mode,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_CLAMP, S_RD, S_FIRE, S_CHK, S_M1, S_M2, S_M3,
        S_CAND, S_SRD, S_SMOD, S_STAT
    } t_state;

    t_state r_state;

    // Configuration
    logic signed [6:0]  r_limit;
    logic signed [10:0] r_gain;
    logic [13:0]        r_hmin;
    logic [13:0]        r_hmax;
    logic [16:0]        r_offset;

    // Latched command word
    logic [2:0]         r_cmd;
    logic [31:0]        r_now;
    logic [3:0]         r_slot;
    logic signed [7:0]  r_temp;

    // Table valid bits and walk state
    logic [rsch_pkg::SLOTS-1:0] r_valid;
    rsch_pkg::t_idx     r_idx;
    logic [31:0]        r_time;
    logic [6:0]         r_flags;
    logic               r_live;
    logic [24:0]        r_x;
    logic [6:0]         r_lo;
    logic               r_wk;
    logic [50:0]        r_p1;
    logic [28:0]        r_p2;
    logic signed [18:0] r_prod;
    logic [13:0]        r_preheat;
    logic               r_cold;
    logic               r_best_any;
    logic [32:0]        r_best_d;
    logic [31:0]        r_best_a;
    logic [31:0]        r_alarm;
    logic               r_alarm_ok;

    // Status fields
    logic               r_ok;
    logic [3:0]         r_rslot;
    logic [31:0]        r_rtime;
    logic [6:0]         r_rmode;

    // Output register
    logic               r_ov;
    logic [1:0]         r_kind;
    logic               r_relay;
    logic               r_osucc;
    logic [3:0]         r_oslot;
    logic [31:0]        r_oatime;
    logic               r_oavalid;
    logic [31:0]        r_ortime;
    logic [6:0]         r_ormode;
    logic               r_olast;

    // RAM port
    logic                            ram_we;
    rsch_pkg::t_idx                  ram_waddr;
    rsch_pkg::t_entry                ram_wdata;
    rsch_pkg::t_idx                  ram_raddr;
    logic [rsch_pkg::ENTRY_W-1:0]    ram_q;
    rsch_pkg::t_entry                rd_e;

    rsch_ram #(
        .WIDTH (rsch_pkg::ENTRY_W),
        .DEPTH (rsch_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign rd_e = rsch_pkg::t_entry'(ram_q);

    logic accept;
    logic out_free;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Decode an incoming add
    logic [6:0]     in_flags;
    logic           add_ok;
    logic           in_range;
    logic           free_any;
    rsch_pkg::t_idx free_idx;

    always_comb begin
        in_flags = '0;
        in_flags[rsch_pkg::FB_ON]     = i_turn_on;
        in_flags[rsch_pkg::FB_OFF]    = !i_turn_on;
        in_flags[rsch_pkg::FB_RELAY2] = i_relay_select;
        in_flags[rsch_pkg::FB_DAILY]  = i_repeat_daily;
        in_flags[rsch_pkg::FB_WEEKLY] = i_repeat_weekly;
        in_flags[rsch_pkg::FB_TEMP]   = i_use_temperature;
        add_ok = !(i_event_time <= i_current_time && !i_repeat_daily && !i_repeat_weekly)
                 && !(i_use_temperature && !i_turn_on);
        in_range = {1'b0, i_slot} < 5'(rsch_pkg::SLOTS);
    end

    // Lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = rsch_pkg::SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_idx = rsch_pkg::t_idx'(k);
            end
        end
    end

    // Status fields of an incoming command
    logic       n_ok;
    logic [3:0] n_rslot;

    always_comb begin
        n_ok    = 1'b0;
        n_rslot = 4'(rsch_pkg::SLOTS);
        case (i_command)
            rsch_pkg::CMD_CLEAR, rsch_pkg::CMD_ALARM: begin
                n_ok = 1'b1;
            end
            rsch_pkg::CMD_ADD: begin
                if (add_ok && free_any) begin
                    n_ok    = 1'b1;
                    n_rslot = 4'(free_idx);
                end
            end
            rsch_pkg::CMD_REMOVE: begin
                n_ok    = in_range;
                n_rslot = i_slot;
            end
            rsch_pkg::CMD_BLOCK, rsch_pkg::CMD_UNBLOCK, rsch_pkg::CMD_QUERY: begin
                n_rslot = i_slot;
            end
            default: begin
            end
        endcase
    end

    // Fire test on the slot just read
    logic        live;
    logic        due_plain;
    logic        due_temp;
    logic        fire_any;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [6:0]  f_flags;
    logic [31:0] f_time;
    logic [32:0] off_sum;

    always_comb begin
        live      = r_valid[r_idx];
        due_plain = !rd_e.flags[rsch_pkg::FB_TEMP] && (rd_e.tm <= r_now);
        due_temp  = r_cold && rd_e.flags[rsch_pkg::FB_TEMP]
                    && ({1'b0, rd_e.tm} < ({1'b0, r_now} + 33'(r_preheat)));
        fire_any  = (r_cmd == rsch_pkg::CMD_ALARM) && live && (due_plain || due_temp);
        emit      = fire_any && !rd_e.flags[rsch_pkg::FB_BLOCK]
                    && (due_plain || rd_e.flags[rsch_pkg::FB_ON]);
        emit_kind = (due_plain && !rd_e.flags[rsch_pkg::FB_ON]) ?
                    rsch_pkg::KIND_OFF : rsch_pkg::KIND_ON;
        off_sum   = {1'b0, rd_e.tm} + 33'(r_offset);
        f_flags   = rd_e.flags;
        f_time    = rd_e.tm;
        if (fire_any) begin
            if (rd_e.flags[rsch_pkg::FB_BLOCK]) begin
                f_flags[rsch_pkg::FB_BLOCK] = 1'b0;
            end else if (due_temp && rd_e.flags[rsch_pkg::FB_ON]) begin
                f_flags[rsch_pkg::FB_ON]   = 1'b0;
                f_flags[rsch_pkg::FB_TEMP] = 1'b0;
                f_flags[rsch_pkg::FB_OFF]  = 1'b1;
                f_time = off_sum[32] ? '1 : off_sum[31:0];
            end
        end
    end

    // Load the output register with a relay word or the status word
    logic out_load;
    assign out_load = out_free && ((r_state == S_FIRE && emit) || r_state == S_STAT);

    // Repeat step: remainder of the elapsed time by the period
    logic [31:0] elapsed;
    logic [15:0] q0;
    logic [25:0] rem;
    logic [25:0] rem_c;
    logic [25:0] per_c;
    logic [32:0] mod_v;
    logic [33:0] n_time;

    always_comb begin
        elapsed = r_now - r_time;
        q0      = r_p1[50:rsch_pkg::REC_SH];
        per_c   = r_wk ? rsch_pkg::WEEK_C[25:0] : rsch_pkg::DAY_C[25:0];
        rem     = 26'(r_x) - r_p2[25:0];
        rem_c   = (rem >= per_c) ? (rem - per_c) : rem;
        mod_v   = {rem_c, r_lo};
        n_time  = {2'b00, r_now} - {1'b0, mod_v}
                  + (r_wk ? rsch_pkg::WEEK_S : rsch_pkg::DAY_S);
    end

    // Alarm candidate of the current slot
    logic [32:0] sum_max;
    logic [32:0] cand_a;
    logic [32:0] cand_d;
    logic        n_best_any;
    logic [32:0] n_best_d;
    logic [31:0] n_best_a;

    always_comb begin
        sum_max = {1'b0, r_now} + 33'(r_hmax);
        if (r_flags[rsch_pkg::FB_TEMP]) begin
            cand_a = ({1'b0, r_time} < sum_max) ? ({1'b0, r_now} + rsch_pkg::PREHEAT_GUARD)
                                                : ({1'b0, r_time} - 33'(r_hmax) + 33'd1);
        end else begin
            cand_a = {1'b0, r_time} + 33'd1;
        end
        cand_d     = cand_a - {1'b0, r_now};
        n_best_any = r_best_any;
        n_best_d   = r_best_d;
        n_best_a   = r_best_a;
        if (r_live && (!r_best_any || cand_d < r_best_d)) begin
            n_best_any = 1'b1;
            n_best_d   = cand_d;
            n_best_a   = cand_a[31:0];
        end
    end

    // Single-slot commands
    rsch_pkg::t_idx sidx;
    logic           s_in;
    logic           s_valid;
    logic [6:0]     s_flags;

    always_comb begin
        sidx    = r_slot[rsch_pkg::IDX_W-1:0];
        s_in    = {1'b0, r_slot} < 5'(rsch_pkg::SLOTS);
        s_valid = s_in && r_valid[sidx];
        s_flags = rd_e.flags;
        s_flags[rsch_pkg::FB_BLOCK] = (r_cmd == rsch_pkg::CMD_BLOCK);
    end

    // RAM port selection
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_idx;
        ram_wdata.tm    = r_time;
        ram_wdata.flags = r_flags;
        ram_raddr       = (r_state == S_SRD) ? sidx : r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept && i_command == rsch_pkg::CMD_ADD && add_ok && free_any) begin
                    ram_we          = 1'b1;
                    ram_waddr       = free_idx;
                    ram_wdata.tm    = i_event_time;
                    ram_wdata.flags = in_flags;
                end
            end
            S_CAND: begin
                ram_we = 1'b1;
            end
            S_SMOD: begin
                if (s_valid && (r_cmd == rsch_pkg::CMD_BLOCK || r_cmd == rsch_pkg::CMD_UNBLOCK))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = sidx;
                    ram_wdata.tm    = rd_e.tm;
                    ram_wdata.flags = s_flags;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 7'sd0;
            r_gain   <= -11'sd60;
            r_hmin   <= 14'd1800;
            r_hmax   <= 14'd7200;
            r_offset <= 17'd3600;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsch_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[6:0];
                rsch_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[10:0];
                rsch_pkg::CFG_HMIN:   r_hmin   <= i_cfg_data[13:0];
                rsch_pkg::CFG_HMAX:   r_hmax   <= i_cfg_data[13:0];
                rsch_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, table walk and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_ov       <= 1'b0;
            r_alarm    <= '0;
            r_alarm_ok <= 1'b0;
            r_preheat  <= '0;
            r_idx      <= '0;
            r_best_any <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_command;
                        r_now      <= i_current_time;
                        r_slot     <= i_slot;
                        r_temp     <= i_outside_temperature;
                        r_rtime    <= '0;
                        r_rmode    <= '0;
                        r_ok       <= n_ok;
                        r_rslot    <= n_rslot;
                        r_idx      <= '0;
                        r_best_any <= 1'b0;
                        case (i_command)
                            rsch_pkg::CMD_CLEAR: begin
                                r_valid    <= '0;
                                r_alarm    <= '0;
                                r_alarm_ok <= 1'b0;
                                r_state    <= S_STAT;
                            end
                            rsch_pkg::CMD_ADD: begin
                                if (add_ok && free_any) begin
                                    r_valid[free_idx] <= 1'b1;
                                end
                                r_state <= S_RD;
                            end
                            rsch_pkg::CMD_REMOVE: begin
                                if (in_range) begin
                                    r_valid[i_slot[rsch_pkg::IDX_W-1:0]] <= 1'b0;
                                end
                                r_state <= S_RD;
                            end
                            rsch_pkg::CMD_BLOCK, rsch_pkg::CMD_UNBLOCK,
                            rsch_pkg::CMD_QUERY: begin
                                r_state <= S_SRD;
                            end
                            rsch_pkg::CMD_ALARM: begin
                                r_state <= S_PRE;
                            end
                            default: begin
                                r_state <= S_STAT;
                            end
                        endcase
                    end
                end
                // Preheat product and cold test
                S_PRE: begin
                    r_prod  <= 19'(r_temp) * 19'(r_gain);
                    r_cold  <= r_temp < 8'(r_limit);
                    r_state <= S_CLAMP;
                end
                // Clamp preheat
                S_CLAMP: begin
                    if (!r_cold) begin
                        r_preheat <= '0;
                    end else if (r_prod < 0 || r_prod > $signed({5'b0, r_hmax})) begin
                        r_preheat <= r_hmax;
                    end else if (r_prod < $signed({5'b0, r_hmin})) begin
                        r_preheat <= r_hmin;
                    end else begin
                        r_preheat <= r_prod[13:0];
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_FIRE;
                end
                // Fire the slot; hold while a relay word cannot be loaded
                S_FIRE: begin
                    if (!emit || out_free) begin
                        r_time  <= f_time;
                        r_flags <= f_flags;
                        r_live  <= live;
                        if (emit) begin
                            r_kind    <= emit_kind;
                            r_relay   <= rd_e.flags[rsch_pkg::FB_RELAY2];
                            r_osucc   <= 1'b1;
                            r_oslot   <= 4'(r_idx);
                            r_oatime  <= '0;
                            r_oavalid <= 1'b0;
                            r_ortime  <= '0;
                            r_ormode  <= '0;
                            r_olast   <= 1'b0;
                        end
                        r_state <= S_CHK;
                    end
                end
                // Drop passed one-shot events, or start the repeat step
                S_CHK: begin
                    if (r_live && r_time <= r_now) begin
                        if (!r_flags[rsch_pkg::FB_DAILY] && !r_flags[rsch_pkg::FB_WEEKLY]) begin
                            r_live  <= 1'b0;
                            r_state <= S_CAND;
                        end else begin
                            r_x     <= elapsed[31:7];
                            r_lo    <= elapsed[6:0];
                            r_wk    <= !r_flags[rsch_pkg::FB_DAILY];
                            r_state <= S_M1;
                        end
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_M1: begin
                    r_p1    <= 51'(r_x) * 51'(r_wk ? rsch_pkg::WEEK_M : rsch_pkg::DAY_M);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_p2    <= 29'(q0) * (r_wk ? rsch_pkg::WEEK_C : rsch_pkg::DAY_C);
                    r_state <= S_M3;
                end
                S_M3: begin
                    if (n_time[33:32] != 2'b00) begin
                        r_live <= 1'b0;
                    end else begin
                        r_time <= n_time[31:0];
                    end
                    r_state <= S_CAND;
                end
                // Write back, keep the earliest alarm, advance
                S_CAND: begin
                    r_valid[r_idx] <= r_live;
                    r_best_any     <= n_best_any;
                    r_best_d       <= n_best_d;
                    r_best_a       <= n_best_a;
                    if (r_idx == rsch_pkg::t_idx'(rsch_pkg::SLOTS - 1)) begin
                        r_alarm_ok <= n_best_any;
                        r_alarm    <= n_best_any ? n_best_a : '0;
                        r_state    <= S_STAT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SMOD;
                end
                // Block, unblock or query one slot
                S_SMOD: begin
                    if (r_cmd == rsch_pkg::CMD_QUERY) begin
                        r_ok    <= s_in;
                        r_rtime <= s_valid ? rd_e.tm : '1;
                        r_rmode <= s_valid ? rd_e.flags : '0;
                    end else begin
                        r_ok <= s_valid;
                    end
                    r_state <= S_STAT;
                end
                // Status word
                S_STAT: begin
                    if (out_free) begin
                        r_kind    <= rsch_pkg::KIND_STATUS;
                        r_relay   <= 1'b0;
                        r_osucc   <= r_ok;
                        r_oslot   <= r_rslot;
                        r_oatime  <= r_alarm;
                        r_oavalid <= r_alarm_ok;
                        r_ortime  <= r_rtime;
                        r_ormode  <= r_rmode;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_relay_number = r_relay;
    assign o_success      = r_osucc;
    assign o_result_slot  = r_oslot;
    assign o_alarm_time   = r_oatime;
    assign o_alarm_valid  = r_oavalid;
    assign o_read_time    = r_ortime;
    assign o_read_mode    = r_ormode;
    assign o_last         = r_olast;

    // An accepted command always leaves the idle state
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("command accepted without leaving idle");

    // No alarm means a zero alarm time
    a_alarm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_alarm_ok |-> (r_alarm == 32'd0))
        else $error("alarm time set without a pending event");

    // Relay words never close a command
    a_relay_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != rsch_pkg::KIND_STATUS) |-> !o_last)
        else $error("relay word marked last");

    // The walk never loads a word over one that is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> r_ov)
        else $error("held output word lost");

endmodule
